>>> rtl/sxfd_pkg.sv
// sxfd_pkg: shared types and constants for the sync/xor frame deframer
// no dependencies; imported by the interfaces, the cells, the checker and the top level
package sxfd_pkg;

    // frame geometry and sync word
    localparam int unsigned FRAME_LEN = 16;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
    localparam logic [7:0]  SYNC_FIRST  = 8'hBB;
    localparam logic [7:0]  SYNC_SECOND = 8'h66;

    typedef logic [7:0] byte_t;

    // checker status handed to the top level
    typedef struct packed {
        logic             full;
        logic             sync_ok;
        logic             sum_ok;
        logic             frame_ok;
        logic [CNT_W-1:0] fill;
    } sxfd_chk_t;

endpackage

>>> rtl/sxfd_byte_if.sv
// sxfd_byte_if: valid/ready channel carrying one received serial byte
// depends on sxfd_pkg
interface sxfd_byte_if
    import sxfd_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/sxfd_frame_if.sv
// sxfd_frame_if: valid/ready channel carrying one decoded frame
// depends on sxfd_pkg
interface sxfd_frame_if
    import sxfd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        gyro_rate_bits;
    byte_t              status_flags;

    modport source (output valid, output left_count, output right_count,
                    output gyro_rate_bits, output status_flags, input ready);
    modport sink   (input valid, input left_count, input right_count,
                    input gyro_rate_bits, input status_flags, output ready);
endinterface

>>> rtl/sxfd_cell.sv
// sxfd_cell: one byte slot of the receive window, shifts toward the head
// depends on sxfd_pkg
module sxfd_cell
    import sxfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  byte_t d_in,
    output byte_t q
);

    byte_t q_reg;
    byte_t q_next;

    // take the neighbor's byte on every accepted request
    always_comb
    begin
        q_next = shift_en ? d_in : q_reg;
    end

    // cleared at reset so the running checksum starts consistent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/sxfd_check.sv
// sxfd_check: fill count, running xor of the window, sync and checksum tests
// depends on sxfd_pkg
module sxfd_check
    import sxfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  byte_t     rx_byte,
    input  byte_t     old_head,
    input  byte_t     head_next,
    input  byte_t     second_next,
    output sxfd_chk_t status
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_LEN - 1);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    byte_t            xor_reg;
    byte_t            xor_next;
    logic             full;
    logic             sync_ok;
    logic             sum_ok;
    logic             frame_ok;

    // tests on the window as it will be after this shift
    always_comb
    begin
        full     = (fill_reg == LAST);
        sync_ok  = (head_next == SYNC_FIRST) && (second_next == SYNC_SECOND);
        // xor of window bytes 0..14 = old cells 1..15 = running xor minus old head
        sum_ok   = ((xor_reg ^ old_head) == rx_byte);
        frame_ok = accept && full && sync_ok && sum_ok;
    end

    // next fill count and running xor of all cells
    always_comb
    begin
        fill_next = fill_reg;
        xor_next  = xor_reg;
        if (accept)
        begin
            xor_next = xor_reg ^ old_head ^ rx_byte;
            if (frame_ok)
            begin
                fill_next = '0;
            end
            else if (!full)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            xor_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            xor_reg  <= xor_next;
        end
    end

    assign status = '{full: full, sync_ok: sync_ok, sum_ok: sum_ok,
                      frame_ok: frame_ok, fill: fill_reg};

endmodule

>>> rtl/sync_xor_frame_deframer_core.sv
// sync_xor_frame_deframer_core: top level, row of byte cells, checker, output register
// depends on sxfd_pkg, sxfd_byte_if, sxfd_frame_if, sxfd_cell, sxfd_check
//
//   channel   dir  handshake        payload
//   rx        in   valid / ready    rx_byte[7:0]
//   frame     out  valid / ready    left_count, right_count, gyro_rate_bits, status_flags
//   cfg       in   cfg_wr_en        cfg_wr_data (swap_wheels)
//
// one byte per cycle while no held frame stalls: the window shifts and is checked in the same cycle it accepts
// a request; a good frame appears on the output register on the next cycle.
// reset clears the window, fill count, running checksum, swap setting and output valid.
// a held frame blocks input only while it stalls; taking it frees input in the same cycle.
module sync_xor_frame_deframer_core
    import sxfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sxfd_byte_if.sink          rx,
    sxfd_frame_if.source       frame,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    byte_t     cell_q [FRAME_LEN];
    byte_t     cell_d [FRAME_LEN];
    logic      accept;
    logic      in_ready;
    sxfd_chk_t chk;

    logic               swap_reg;
    logic               swap_next;
    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] left_reg;
    logic signed [31:0] left_next;
    logic signed [31:0] right_reg;
    logic signed [31:0] right_next;
    logic [31:0]        gyro_reg;
    logic [31:0]        gyro_next;
    byte_t              flags_reg;
    byte_t              flags_next;
    logic [31:0]        word_a;
    logic [31:0]        word_b;

    // input handshake
    assign in_ready = !valid_reg || frame.ready;
    assign rx.ready = in_ready;
    assign accept   = rx.valid && in_ready;

    // cell chain: newest byte enters at the tail, each cell takes its neighbor
    genvar gi;
    generate
        for (gi = 0; gi < FRAME_LEN; gi++)
        begin : g_cell
            if (gi == FRAME_LEN - 1)
            begin : g_tail
                assign cell_d[gi] = rx.rx_byte;
            end
            else
            begin : g_body
                assign cell_d[gi] = cell_q[gi+1];
            end
            sxfd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .d_in     (cell_d[gi]),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    // sync and checksum tests
    sxfd_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .old_head    (cell_q[0]),
        .head_next   (cell_d[0]),
        .second_next (cell_d[1]),
        .status      (chk)
    );

    // little-endian fields of the window after the shift
    always_comb
    begin
        word_a = {cell_d[5], cell_d[4], cell_d[3], cell_d[2]};
        word_b = {cell_d[9], cell_d[8], cell_d[7], cell_d[6]};
    end

    // output register and configuration
    always_comb
    begin
        swap_next  = cfg_wr_en ? cfg_wr_data : swap_reg;
        valid_next = valid_reg;
        left_next  = left_reg;
        right_next = right_reg;
        gyro_next  = gyro_reg;
        flags_next = flags_reg;
        if (frame.ready)
        begin
            valid_next = 1'b0;
        end
        if (chk.frame_ok)
        begin
            valid_next = 1'b1;
            left_next  = swap_reg ? word_b : word_a;
            right_next = swap_reg ? word_a : word_b;
            gyro_next  = {cell_d[13], cell_d[12], cell_d[11], cell_d[10]};
            flags_next = cell_d[14];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            swap_reg  <= swap_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        gyro_reg  <= gyro_next;
        flags_reg <= flags_next;
    end

    assign frame.valid          = valid_reg;
    assign frame.left_count     = left_reg;
    assign frame.right_count    = right_reg;
    assign frame.gyro_rate_bits = gyro_reg;
    assign frame.status_flags   = flags_reg;

`ifndef NO_ASSERTIONS
    // a new frame only follows an accepted request
    a_frame_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_next && !valid_reg) |-> accept)
        else $error("frame raised without an accepted request");

    // a stalled frame blocks further input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && !frame.ready) |-> !rx.ready)
        else $error("input accepted while output stalled");

    // a good frame needs a full window and empties it
    a_frame_empties: assert property (@(posedge clk) disable iff (!rst_n)
        chk.frame_ok |-> (chk.full && chk.sync_ok && chk.sum_ok) ##1 (chk.fill == '0))
        else $error("good frame without full window or window not emptied");
`endif

endmodule

>>> dv/tb.sv
// tb: self-checking bench for sync_xor_frame_deframer_core, byte stream in, decoded frames out
// depends on sxfd_pkg, sxfd_byte_if, sxfd_frame_if and the core rtl
// frames are predicted in-bench from every accepted byte and compared in order
`timescale 1ns / 1ps

module tb;
    import sxfd_pkg::*;

    localparam int QUIET_CYCLES   = 8;
    localparam int PHASE_BYTES    = 325;
    localparam int NUM_PHASES     = 4;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {FRM_GOOD, FRM_BAD_SYNC, FRM_BAD_SUM} frame_kind_t;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [31:0]        gyro_rate_bits;
        byte_t              status_flags;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    sxfd_byte_if  rx_ch ();
    sxfd_frame_if frame_ch ();

    sync_xor_frame_deframer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_ch),
        .frame       (frame_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // bytes waiting to be sent, frames waiting to be seen
    byte_t  tx_bytes[$];
    frame_t expected_frames[$];
    int     mismatches = 0;

    // shadow copy of the window and the swap setting
    byte_t  win[FRAME_LEN];
    int     win_fill = 0;
    logic   swap_setting = 1'b0;

    // push one byte into the shadow window and queue a frame when it decodes
    task automatic deframe_byte(input byte_t b);
        byte_t       sum;
        frame_t      f;
        logic [31:0] first_word;
        logic [31:0] second_word;
        int          i;
        if (win_fill >= FRAME_LEN)
            win_fill = FRAME_LEN - 1;
        win[win_fill] = b;
        win_fill++;
        if (win_fill < FRAME_LEN)
            return;
        sum = '0;
        for (i = 0; i < FRAME_LEN - 1; i++)
            sum ^= win[i];
        if (win[0] != SYNC_FIRST || win[1] != SYNC_SECOND || sum != win[FRAME_LEN-1])
        begin
            // resync: slide out the oldest byte
            for (i = 0; i < FRAME_LEN - 1; i++)
                win[i] = win[i+1];
            win_fill = FRAME_LEN - 1;
            return;
        end
        first_word  = {win[5], win[4], win[3], win[2]};
        second_word = {win[9], win[8], win[7], win[6]};
        f.left_count     = swap_setting ? second_word : first_word;
        f.right_count    = swap_setting ? first_word : second_word;
        f.gyro_rate_bits = {win[13], win[12], win[11], win[10]};
        f.status_flags   = win[14];
        expected_frames.insert(expected_frames.size(), f);
        win_fill = 0;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %h got %h", what, want, got);
        end
    endtask

    // track config writes and accepted requests at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                swap_setting = cfg_wr_data;
            if (rx_ch.valid && rx_ch.ready)
                deframe_byte(rx_ch.rx_byte);
        end
    end

    // byte driver: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            burst_left    <= 1;
            gap_left      <= 0;
        end
        else if (!rx_ch.valid || rx_ch.ready)
        begin
            if (gap_left > 0)
            begin
                rx_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end
            else if (tx_bytes.size() > 0)
            begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= tx_bytes[0];
                tx_bytes.delete(0);
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                rx_ch.valid <= 1'b0;
        end
    end

    // frame sink: stall mode follows the top two bits of a free-running counter
    logic [7:0] stall_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            stall_cnt      <= '0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1'b1;
            case (stall_cnt[7:6])
                2'd0:    frame_ch.ready <= 1'b1;
                2'd1:    frame_ch.ready <= 1'($urandom_range(0, 1));
                2'd2:    frame_ch.ready <= (stall_cnt[1:0] == 2'd3);
                default: frame_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // compare each taken frame against the oldest prediction
    always @(posedge clk)
    begin : frame_monitor
        frame_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected frame: left %h right %h gyro %h flags %h",
                             frame_ch.left_count, frame_ch.right_count,
                             frame_ch.gyro_rate_bits, frame_ch.status_flags);
            end
            else
            begin
                want = expected_frames[0];
                expected_frames.delete(0);
                check_field("left_count", want.left_count, frame_ch.left_count);
                check_field("right_count", want.right_count, frame_ch.right_count);
                check_field("gyro_rate_bits", want.gyro_rate_bits, frame_ch.gyro_rate_bits);
                check_field("status_flags", {24'h0, want.status_flags},
                            {24'h0, frame_ch.status_flags});
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // build one 16-byte frame, optionally broken in sync or checksum
    task automatic push_frame(input frame_kind_t kind, input logic [31:0] lc,
                              input logic [31:0] rc, input logic [31:0] gyro,
                              input byte_t flags);
        byte_t fb[FRAME_LEN];
        byte_t sum;
        int    i;
        fb[0] = SYNC_FIRST;
        fb[1] = SYNC_SECOND;
        for (i = 0; i < 4; i++)
        begin
            fb[2+i]  = lc[8*i +: 8];
            fb[6+i]  = rc[8*i +: 8];
            fb[10+i] = gyro[8*i +: 8];
        end
        fb[14] = flags;
        if (kind == FRM_BAD_SYNC)
        begin
            if ($urandom_range(0, 1))
                do fb[0] = byte_t'($urandom_range(0, 255)); while (fb[0] == SYNC_FIRST);
            else
                do fb[1] = byte_t'($urandom_range(0, 255)); while (fb[1] == SYNC_SECOND);
        end
        sum = '0;
        for (i = 0; i < FRAME_LEN - 1; i++)
            sum ^= fb[i];
        if (kind == FRM_BAD_SUM)
            sum ^= byte_t'($urandom_range(1, 255));
        fb[FRAME_LEN-1] = sum;
        for (i = 0; i < FRAME_LEN; i++)
            tx_bytes.insert(tx_bytes.size(), fb[i]);
    endtask

    // mostly good frames, some broken ones and stray bytes
    task automatic push_random(output int n);
        int pick;
        int i;
        pick = $urandom_range(0, 99);
        n    = FRAME_LEN;
        if (pick < 70)
            push_frame(FRM_GOOD, rand_word(), rand_word(), rand_word(),
                       byte_t'($urandom_range(0, 255)));
        else if (pick < 80)
            push_frame(FRM_BAD_SYNC, rand_word(), rand_word(), rand_word(),
                       byte_t'($urandom_range(0, 255)));
        else if (pick < 88)
            push_frame(FRM_BAD_SUM, rand_word(), rand_word(), rand_word(),
                       byte_t'($urandom_range(0, 255)));
        else
        begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0, 1:    tx_bytes.insert(tx_bytes.size(), SYNC_FIRST);
                    2:       tx_bytes.insert(tx_bytes.size(), SYNC_SECOND);
                    default: tx_bytes.insert(tx_bytes.size(),
                                             byte_t'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // wait until input and output have stayed quiet
    task automatic drain();
        int quiet;
        quiet = 0;
        while (quiet < QUIET_CYCLES)
        begin
            @(negedge clk);
            if (tx_bytes.size() != 0 || rx_ch.valid || expected_frames.size() != 0
                || frame_ch.valid)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_swap(input logic value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin : stimulus
        int phase;
        int issued;
        int n;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_swap(1'b0);

        // stray sync byte in front, then a bad checksum, then a good frame at the extremes
        tx_bytes.insert(tx_bytes.size(), SYNC_FIRST);
        push_frame(FRM_BAD_SUM, 32'h1234_5678, 32'h9ABC_DEF0, 32'h3F80_0000, 8'h04);
        push_frame(FRM_GOOD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h05);
        drain();

        // random phases, alternating the wheel swap
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_swap(phase % 2 == 0);
            issued = 0;
            while (issued < PHASE_BYTES)
            begin
                push_random(n);
                issued += n;
            end
            drain();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sxfd_pkg.sv
rtl/sxfd_byte_if.sv
rtl/sxfd_frame_if.sv
rtl/sxfd_cell.sv
rtl/sxfd_check.sv
rtl/sync_xor_frame_deframer_core.sv
dv/tb.sv
